// ===== rtl/core/button_box_to_stick_report_unit_defines.svh =====
// Assertion macros for the button box report block.
`ifndef BUTTON_BOX_TO_STICK_REPORT_UNIT_DEFINES_SVH
`define BUTTON_BOX_TO_STICK_REPORT_UNIT_DEFINES_SVH

// same-cycle implication, checked after reset
`define BBSR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked after reset
`define BBSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/bbsr_pkg.sv =====
package bbsr_pkg;

    typedef struct packed {
        logic [3:0] direction_buttons;
        logic [3:0] c_buttons;
        logic [1:0] modifier_buttons;
        logic [3:0] shoulder_buttons;
        logic [5:0] action_buttons;
    } item_t;

    typedef struct packed {
        logic [7:0] stick_x;
        logic [7:0] stick_y;
        logic [7:0] cstick_x;
        logic [7:0] cstick_y;
        logic [7:0] trigger_left;
        logic [7:0] trigger_right;
        logic [3:0] dpad;
        logic [7:0] digital_buttons;
    } report_t;

    // direction tracking state for second-input priority
    typedef struct packed {
        logic [3:0] held;
        logic [3:0] lock;
    } dir_state_t;

    typedef struct packed {
        logic ban_parasol_dash;
        logic ban_slight_side_b;
    } cfg_t;

    typedef enum logic [0:0] {
        REG_BAN_PARASOL_DASH  = 1'b0,
        REG_BAN_SLIGHT_SIDE_B = 1'b1
    } cfg_index_t;

    localparam logic [7:0] CENTRE     = 8'd128;
    localparam logic [7:0] TRIG_FULL  = 8'd140;
    localparam logic [7:0] TRIG_MID   = 8'd94;
    localparam logic [7:0] TRIG_LIGHT = 8'd49;

    // offsets from centre in units of 1/80 full deflection, (x, y) pairs
    // ordered by c down, c left, c up, c right, none
    localparam logic [7:0] TAB_BX [10] = '{8'd73, 8'd36, 8'd68, 8'd42, 8'd59,
                                           8'd43, 8'd51, 8'd43, 8'd73, 8'd31};
    localparam logic [7:0] TAB_BY [10] = '{8'd36, 8'd70, 8'd42, 8'd68, 8'd47,
                                           8'd64, 8'd47, 8'd57, 8'd31, 8'd73};
    localparam logic [7:0] TAB_MX [10] = '{8'd56, 8'd29, 8'd63, 8'd39, 8'd56,
                                           8'd41, 8'd49, 8'd42, 8'd59, 8'd25};
    localparam logic [7:0] TAB_MY [10] = '{8'd29, 8'd56, 8'd39, 8'd63, 8'd41,
                                           8'd56, 8'd51, 8'd61, 8'd25, 8'd59};

endpackage

// ===== rtl/core/bbsr_map.sv =====
module bbsr_map
    import bbsr_pkg::*;
(
    input  item_t      item,
    input  cfg_t       cfg,
    input  dir_state_t st,
    output dir_state_t st_next,
    output report_t    rpt
);

    logic [3:0] raw;
    logic [3:0] lock_set;
    logic [3:0] lock_new;
    logic [3:0] eff;
    logic       bothh;
    logic       bothv;
    logic       l, r, u, d;
    logic       cl, cr, cu, cd;
    logic       mx, my, bl, br, bb;
    logic       vert, horiz, cvert, choriz;
    logic [2:0] k;
    logic [3:0] ix;
    logic [3:0] iy;
    logic [7:0] x, y, cx, cy;

    always_comb
    begin
        raw   = item.direction_buttons;
        bothh = (raw[1:0] == 2'b11);
        bothv = (raw[3:2] == 2'b11);

        lock_set = st.lock;
        if (st.held[0] && bothh && !st.held[1]) lock_set[0] = 1'b1;
        if (st.held[1] && bothh && !st.held[0]) lock_set[1] = 1'b1;
        if (st.held[2] && bothv && !st.held[3]) lock_set[2] = 1'b1;
        if (st.held[3] && bothv && !st.held[2]) lock_set[3] = 1'b1;
        lock_new = lock_set & raw;
        eff      = raw & ~lock_new;

        l  = eff[0];
        r  = eff[1];
        u  = eff[2];
        d  = eff[3];
        cl = item.c_buttons[0];
        cr = item.c_buttons[1];
        cu = item.c_buttons[2];
        cd = item.c_buttons[3];
        mx = item.modifier_buttons[0];
        my = item.modifier_buttons[1];
        bl = item.shoulder_buttons[0];
        br = item.shoulder_buttons[1];
        bb = item.action_buttons[1];

        vert  = u || d;
        horiz = l || r;

        k  = cd ? 3'd0 : cl ? 3'd1 : cu ? 3'd2 : cr ? 3'd3 : 3'd4;
        ix = {k, 1'b0};
        iy = {k, 1'b1};

        x = 8'd0;
        y = 8'd0;
        if (vert && horiz)
        begin
            if (bl || br)
            begin
                if (mx == my)
                begin
                    x = 8'd56;
                    y = u ? 8'd56 : 8'd55;
                end
                else if (mx)
                begin
                    x = 8'd51;
                    y = 8'd30;
                end
                else if (cfg.ban_parasol_dash && u)
                begin
                    x = 8'd70;
                    y = 8'd38;
                end
                else
                begin
                    x = 8'd68;
                    y = 8'd40;
                end
            end
            else if (mx != my)
            begin
                if (bb)
                begin
                    x = mx ? TAB_BX[ix] : TAB_BY[ix];
                    y = mx ? TAB_BX[iy] : TAB_BY[iy];
                end
                else
                begin
                    x = mx ? TAB_MX[ix] : TAB_MY[ix];
                    y = mx ? TAB_MX[iy] : TAB_MY[iy];
                end
            end
            else
            begin
                x = 8'd56;
                y = 8'd56;
            end
        end
        else if (horiz)
        begin
            if (mx == my)
                x = 8'd80;
            else if (mx)
                x = (l && r) ? 8'd80 : 8'd53;
            else
                x = ((cfg.ban_slight_side_b && bb) || (l && r)) ? 8'd80 : 8'd27;
        end
        else if (vert)
        begin
            if (mx == my)
                y = 8'd80;
            else if (mx)
                y = 8'd43;
            else
                y = 8'd59;
        end

        cvert  = cu != cd;
        choriz = cl != cr;
        cx = 8'd0;
        cy = 8'd0;
        if (mx && my)
        begin
            cx = 8'd0;
            cy = 8'd0;
        end
        else if (cvert && choriz)
        begin
            cx = 8'd42;
            cy = 8'd68;
        end
        else if (choriz)
        begin
            if (mx)
            begin
                cx = 8'd67;
                cy = u ? 8'd25 : 8'd231;   // -25
            end
            else
                cx = 8'd80;
        end
        else if (cvert)
            cy = 8'd80;

        rpt.stick_x  = (horiz && !r) ? CENTRE - x : CENTRE + x;
        rpt.stick_y  = (vert && !u) ? CENTRE - y : CENTRE + y;
        rpt.cstick_x = (choriz && cl) ? CENTRE - cx : CENTRE + cx;
        rpt.cstick_y = (cvert && cd) ? CENTRE - cy : CENTRE + cy;

        rpt.trigger_left  = bl ? TRIG_FULL :
                            item.shoulder_buttons[3] ? TRIG_MID :
                            item.shoulder_buttons[2] ? TRIG_LIGHT : 8'd0;
        rpt.trigger_right = br ? TRIG_FULL : 8'd0;
        rpt.dpad          = (mx && my) ? {cr, cu, cl, cd} : 4'd0;
        rpt.digital_buttons = {item.action_buttons[5], br, bl, item.action_buttons[4:0]};

        st_next.held = raw;
        st_next.lock = lock_new;
    end

endmodule

// ===== rtl/core/button_box_to_stick_report_unit.sv =====
// Button box to pad report.
// Input channel: in_valid / in_stall with one button snapshot per item.
// Output channel: out_valid / out_stall with one pad report per item.
// Config port: cfg_we, cfg_index, cfg_data; write only while idle.
//   index 0: ban_parasol_dash, index 1: ban_slight_side_b.
// Each accepted item passes through the input register, then the report
// register; one item per cycle is sustained while the receiver does not stall.
// Opposing-direction lockout state advances as each item moves from the
// input register into the report register.
// When the receiver stalls, the report holds; one more item waits in the
// input register, then in_stall rises until the report is taken.
// Reset clears both valids, the lockout state and the config bits.
`include "button_box_to_stick_report_unit_defines.svh"

module button_box_to_stick_report_unit
    import bbsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [3:0] direction_buttons,
    input  logic [3:0] c_buttons,
    input  logic [1:0] modifier_buttons,
    input  logic [3:0] shoulder_buttons,
    input  logic [5:0] action_buttons,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] stick_x,
    output logic [7:0] stick_y,
    output logic [7:0] cstick_x,
    output logic [7:0] cstick_y,
    output logic [7:0] trigger_left,
    output logic [7:0] trigger_right,
    output logic [3:0] dpad,
    output logic [7:0] digital_buttons,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [0:0] cfg_data
);

    logic       s1_valid_reg;
    item_t      s1_item_reg;
    logic       out_valid_reg;
    report_t    out_rpt_reg;
    dir_state_t st_reg;
    dir_state_t st_next;
    cfg_t       cfg_reg;
    report_t    rpt_next;
    logic       out_free;
    logic       s1_adv;
    logic       in_acc;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_acc   = in_valid && !in_stall;

    bbsr_map u_map
    (
        .item    (s1_item_reg),
        .cfg     (cfg_reg),
        .st      (st_reg),
        .st_next (st_next),
        .rpt     (rpt_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
            cfg_reg       <= '0;
        end
        else
        begin
            if (in_acc)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (s1_adv)
                st_reg <= st_next;
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    REG_BAN_PARASOL_DASH:  cfg_reg.ban_parasol_dash  <= cfg_data[0];
                    REG_BAN_SLIGHT_SIDE_B: cfg_reg.ban_slight_side_b <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_item_reg.direction_buttons <= direction_buttons;
            s1_item_reg.c_buttons         <= c_buttons;
            s1_item_reg.modifier_buttons  <= modifier_buttons;
            s1_item_reg.shoulder_buttons  <= shoulder_buttons;
            s1_item_reg.action_buttons    <= action_buttons;
        end
        if (s1_adv)
            out_rpt_reg <= rpt_next;
    end

    assign out_valid       = out_valid_reg;
    assign stick_x         = out_rpt_reg.stick_x;
    assign stick_y         = out_rpt_reg.stick_y;
    assign cstick_x        = out_rpt_reg.cstick_x;
    assign cstick_y        = out_rpt_reg.cstick_y;
    assign trigger_left    = out_rpt_reg.trigger_left;
    assign trigger_right   = out_rpt_reg.trigger_right;
    assign dpad            = out_rpt_reg.dpad;
    assign digital_buttons = out_rpt_reg.digital_buttons;

    `BBSR_ASSERT_NOW(a_lock_held, 1'b1, (st_reg.lock & ~st_reg.held) == 4'd0,
        "lockout set on a released direction")
    `BBSR_ASSERT_NOW(a_stall_full, in_stall, s1_valid_reg && out_valid_reg,
        "input stalled with a free stage")
    `BBSR_ASSERT_NEXT(a_adv_valid, s1_adv, out_valid_reg,
        "item lost between stages")
    `BBSR_ASSERT_NOW(a_trig_r, out_valid_reg,
        trigger_right == TRIG_FULL || trigger_right == 8'd0,
        "bad right trigger level")

endmodule
